FILE: rtl/fca_pkg.sv
// Shared types, constants and the microcode program of the fixed chunk allocator.
// No dependencies; used by fca_seq and fixed_chunk_allocator.
`default_nettype none

package fca_pkg;

    localparam int MAX_CHUNKS = 1024;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int NUM_W      = IDX_W + 1;
    localparam int ADDR_W     = 32;
    localparam int CS_W       = 16;
    localparam int ST_W       = 3;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int PROD_W     = IDX_W + CS_W;

    // divider retires two quotient bits per step
    localparam int DIV_STEPS  = ADDR_W / 2;
    localparam int DIVC_W     = $clog2(DIV_STEPS);
    localparam int SCNT_W     = (IDX_W > DIVC_W) ? IDX_W : DIVC_W;

    localparam logic [CS_W-1:0]  CS_RESET  = CS_W'(64);
    localparam logic [NUM_W-1:0] NUM_MAX   = NUM_W'(MAX_CHUNKS);

    // register indexes
    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_CSIZE  = 2'd1;
    localparam logic [1:0] REG_NCHUNK = 2'd2;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_NONE     = 3'd1,
        ST_MISALIGN = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FREE     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        U_NOP,
        U_LOAD,
        U_STK_RD,
        U_POP,
        U_GRANT,
        U_DIV_INIT,
        U_DIV_STEP,
        U_FLAG_RD,
        U_PUSH,
        U_SET_FREE,
        U_SET_RANGE,
        U_SET_MIS,
        U_SET_NONE,
        U_EMIT,
        U_CLR_MEM
    } t_uop;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_IS_RET,
        C_STK_EMPTY,
        C_CS_ZERO,
        C_DIV_MORE,
        C_REM_NZ,
        C_QUO_BIG,
        C_FLAG_CLR,
        C_OUT_FULL,
        C_CLR_MORE
    } t_cond;

    localparam int UPC_W = 5;

    localparam logic [UPC_W-1:0] S_WAIT      = UPC_W'(0);
    localparam logic [UPC_W-1:0] S_DISPATCH  = UPC_W'(1);
    localparam logic [UPC_W-1:0] S_STK_RD    = UPC_W'(2);
    localparam logic [UPC_W-1:0] S_POP       = UPC_W'(3);
    localparam logic [UPC_W-1:0] S_GRANT     = UPC_W'(4);
    localparam logic [UPC_W-1:0] S_DIV_INIT  = UPC_W'(5);
    localparam logic [UPC_W-1:0] S_DIV       = UPC_W'(6);
    localparam logic [UPC_W-1:0] S_REM_CHK   = UPC_W'(7);
    localparam logic [UPC_W-1:0] S_RANGE_CHK = UPC_W'(8);
    localparam logic [UPC_W-1:0] S_FLAG_RD   = UPC_W'(9);
    localparam logic [UPC_W-1:0] S_FLAG_CHK  = UPC_W'(10);
    localparam logic [UPC_W-1:0] S_PUSH      = UPC_W'(11);
    localparam logic [UPC_W-1:0] S_SET_FREE  = UPC_W'(12);
    localparam logic [UPC_W-1:0] S_SET_RANGE = UPC_W'(13);
    localparam logic [UPC_W-1:0] S_SET_MIS   = UPC_W'(14);
    localparam logic [UPC_W-1:0] S_SET_NONE  = UPC_W'(15);
    localparam logic [UPC_W-1:0] S_EMIT      = UPC_W'(16);
    localparam logic [UPC_W-1:0] S_CLEAR     = UPC_W'(17);

    typedef struct packed {
        t_uop             op;
        t_cond            cond;
        logic             last;
        logic [UPC_W-1:0] target;
    } t_ctrl;

    // condition inputs from the datapath to the sequencer
    typedef struct packed {
        logic no_accept;
        logic is_ret;
        logic stk_empty;
        logic cs_zero;
        logic div_more;
        logic rem_nz;
        logic quo_big;
        logic flag_clr;
        logic out_full;
        logic clr_more;
    } t_flags;

    // microcode: the branch is taken when cond holds, else last returns to S_WAIT,
    // else the step counter advances
    function automatic t_ctrl rom_word(input logic [UPC_W-1:0] a);
        t_ctrl w;
        w = '{op: U_NOP, cond: C_ALWAYS, last: 1'b0, target: S_WAIT};
        case (a)
            S_WAIT:      w = '{U_LOAD,      C_NO_ACCEPT, 1'b0, S_WAIT};
            S_DISPATCH:  w = '{U_NOP,       C_IS_RET,    1'b0, S_DIV_INIT};
            S_STK_RD:    w = '{U_STK_RD,    C_STK_EMPTY, 1'b0, S_SET_NONE};
            S_POP:       w = '{U_POP,       C_NONE,      1'b0, S_WAIT};
            S_GRANT:     w = '{U_GRANT,     C_ALWAYS,    1'b0, S_EMIT};
            S_DIV_INIT:  w = '{U_DIV_INIT,  C_CS_ZERO,   1'b0, S_SET_MIS};
            S_DIV:       w = '{U_DIV_STEP,  C_DIV_MORE,  1'b0, S_DIV};
            S_REM_CHK:   w = '{U_NOP,       C_REM_NZ,    1'b0, S_SET_MIS};
            S_RANGE_CHK: w = '{U_NOP,       C_QUO_BIG,   1'b0, S_SET_RANGE};
            S_FLAG_RD:   w = '{U_FLAG_RD,   C_NONE,      1'b0, S_WAIT};
            S_FLAG_CHK:  w = '{U_NOP,       C_FLAG_CLR,  1'b0, S_SET_FREE};
            S_PUSH:      w = '{U_PUSH,      C_ALWAYS,    1'b0, S_EMIT};
            S_SET_FREE:  w = '{U_SET_FREE,  C_ALWAYS,    1'b0, S_EMIT};
            S_SET_RANGE: w = '{U_SET_RANGE, C_ALWAYS,    1'b0, S_EMIT};
            S_SET_MIS:   w = '{U_SET_MIS,   C_ALWAYS,    1'b0, S_EMIT};
            S_SET_NONE:  w = '{U_SET_NONE,  C_ALWAYS,    1'b0, S_EMIT};
            S_EMIT:      w = '{U_EMIT,      C_OUT_FULL,  1'b1, S_EMIT};
            S_CLEAR:     w = '{U_CLR_MEM,   C_CLR_MORE,  1'b1, S_CLEAR};
            default:     w = '{U_NOP,       C_ALWAYS,    1'b0, S_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fca_seq.sv
// Microcode sequencer of the chunk allocator: step counter, program ROM, branch logic.
// Depends on fca_pkg for the control word, condition codes and the program.
`default_nettype none

module fca_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_restart,
    input  wire fca_pkg::t_flags i_flags,
    output fca_pkg::t_ctrl      o_ctrl,
    output logic                o_idle
);

    logic [fca_pkg::UPC_W-1:0] r_upc;
    logic [fca_pkg::UPC_W-1:0] n_upc;
    logic                      take;
    fca_pkg::t_ctrl            ctrl;

    assign ctrl   = fca_pkg::rom_word(r_upc);
    assign o_ctrl = ctrl;
    assign o_idle = (r_upc == fca_pkg::S_WAIT);

    always_comb begin
        unique case (ctrl.cond)
            fca_pkg::C_NONE:      take = 1'b0;
            fca_pkg::C_ALWAYS:    take = 1'b1;
            fca_pkg::C_NO_ACCEPT: take = i_flags.no_accept;
            fca_pkg::C_IS_RET:    take = i_flags.is_ret;
            fca_pkg::C_STK_EMPTY: take = i_flags.stk_empty;
            fca_pkg::C_CS_ZERO:   take = i_flags.cs_zero;
            fca_pkg::C_DIV_MORE:  take = i_flags.div_more;
            fca_pkg::C_REM_NZ:    take = i_flags.rem_nz;
            fca_pkg::C_QUO_BIG:   take = i_flags.quo_big;
            fca_pkg::C_FLAG_CLR:  take = i_flags.flag_clr;
            fca_pkg::C_OUT_FULL:  take = i_flags.out_full;
            fca_pkg::C_CLR_MORE:  take = i_flags.clr_more;
            default:              take = 1'b0;
        endcase
    end

    always_comb begin
        if (i_restart) begin
            n_upc = fca_pkg::S_CLEAR;
        end else if (take) begin
            n_upc = ctrl.target;
        end else if (ctrl.last) begin
            n_upc = fca_pkg::S_WAIT;
        end else begin
            n_upc = r_upc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= fca_pkg::S_CLEAR;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fixed_chunk_allocator.sv
// Fixed chunk allocator top level: APB registers, free stack and in-use memories, datapath.
// Depends on fca_pkg and fca_seq.
//
// One request is worked at a time. An allocate reads and pops the free stack and forms the
// grant before its result is emitted; a return first runs the offset/chunk_size divider,
// which retires two quotient bits per cycle. A new request is taken while a finished result
// still waits at the output. After reset and after every num_chunks write the block sweeps
// its 1024-entry memories, one entry a cycle, and holds o_stall high meanwhile,
// starting with the cycle of the write; register writes are taken throughout.
`default_nettype none

module fixed_chunk_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_action,
    input  wire logic [fca_pkg::ADDR_W-1:0]    i_address,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [fca_pkg::ST_W-1:0]           o_status,
    output logic [fca_pkg::ADDR_W-1:0]         o_granted_address,
    output logic [fca_pkg::IDX_W-1:0]          o_chunk_index,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fca_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [fca_pkg::PDATA_W-1:0]   pwdata,
    output logic [fca_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int IDX_W  = fca_pkg::IDX_W;
    localparam int NUM_W  = fca_pkg::NUM_W;
    localparam int ADDR_W = fca_pkg::ADDR_W;
    localparam int CS_W   = fca_pkg::CS_W;
    localparam int SCNT_W = fca_pkg::SCNT_W;

    // ---------------- registers ----------------
    logic [ADDR_W-1:0] r_base;
    logic [CS_W-1:0]   r_csize;
    logic [NUM_W-1:0]  r_num;
    logic              cfg_wr;
    logic [1:0]        reg_idx;
    logic [NUM_W-1:0]  num_wr;
    logic              restart;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign num_wr  = (pwdata[NUM_W-1:0] > fca_pkg::NUM_MAX) ? fca_pkg::NUM_MAX
                                                            : pwdata[NUM_W-1:0];
    assign restart = cfg_wr && (reg_idx == fca_pkg::REG_NCHUNK);

    always_comb begin
        unique case (reg_idx)
            fca_pkg::REG_BASE:   prdata = fca_pkg::PDATA_W'(r_base);
            fca_pkg::REG_CSIZE:  prdata = fca_pkg::PDATA_W'(r_csize);
            fca_pkg::REG_NCHUNK: prdata = fca_pkg::PDATA_W'(r_num);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_csize <= fca_pkg::CS_RESET;
            r_num   <= fca_pkg::NUM_MAX;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                fca_pkg::REG_BASE:   r_base  <= pwdata[ADDR_W-1:0];
                fca_pkg::REG_CSIZE:  r_csize <= pwdata[CS_W-1:0];
                fca_pkg::REG_NCHUNK: r_num   <= num_wr;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    fca_pkg::t_ctrl  ctrl;
    fca_pkg::t_flags flags;
    logic            idle;
    logic            in_xfer;

    fca_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_flags   (flags),
        .o_ctrl    (ctrl),
        .o_idle    (idle)
    );

    // a num_chunks write sends the sequencer to the sweep, so no transfer then
    assign o_stall = !idle || restart;
    assign in_xfer = i_valid && !o_stall;

    // ---------------- datapath state ----------------
    logic                      r_action;
    logic [ADDR_W-1:0]         r_quo;      // offset, shifted into quotient
    logic [CS_W-1:0]           r_rem;
    logic [SCNT_W-1:0]         r_cnt;
    logic [NUM_W-1:0]          r_fc;
    logic [IDX_W-1:0]          r_idx;
    logic [fca_pkg::PROD_W-1:0] r_prod;
    logic [ADDR_W-1:0]         r_gaddr;
    fca_pkg::t_status          r_status;

    logic                      r_out_valid;
    fca_pkg::t_status          r_o_status;
    logic [ADDR_W-1:0]         r_o_gaddr;
    logic [IDX_W-1:0]          r_o_idx;
    logic                      out_full;
    logic                      emit;

    assign out_full = r_out_valid && i_stall;
    assign emit     = (ctrl.op == fca_pkg::U_EMIT) && !out_full;

    // two restoring division bits
    logic [CS_W:0]     t1, t2;
    logic              ge1, ge2;
    logic [CS_W-1:0]   rem1, rem2;
    logic [ADDR_W-1:0] q1, q2;

    always_comb begin
        t1   = {r_rem, r_quo[ADDR_W-1]};
        ge1  = (t1 >= {1'b0, r_csize});
        rem1 = ge1 ? CS_W'(t1 - {1'b0, r_csize}) : t1[CS_W-1:0];
        q1   = {r_quo[ADDR_W-2:0], ge1};
        t2   = {rem1, q1[ADDR_W-1]};
        ge2  = (t2 >= {1'b0, r_csize});
        rem2 = ge2 ? CS_W'(t2 - {1'b0, r_csize}) : t2[CS_W-1:0];
        q2   = {q1[ADDR_W-2:0], ge2};
    end

    // ---------------- memories ----------------
    logic [IDX_W-1:0] r_stack [fca_pkg::MAX_CHUNKS];
    logic             r_flags [fca_pkg::MAX_CHUNKS];
    logic [IDX_W-1:0] r_stk_q;
    logic             r_flag_q;

    logic             stk_we, stk_re, flag_we, flag_re, flag_wd, push_ok;
    logic [IDX_W-1:0] stk_wa, stk_wd, stk_ra, flag_wa, flag_ra;

    assign push_ok = (r_fc < r_num);

    always_comb begin
        stk_we  = 1'b0;
        stk_wa  = r_fc[IDX_W-1:0];
        stk_wd  = r_idx;
        stk_re  = (ctrl.op == fca_pkg::U_STK_RD);
        stk_ra  = IDX_W'(r_fc - 1'b1);
        flag_we = 1'b0;
        flag_wa = r_idx;
        flag_wd = 1'b0;
        flag_re = (ctrl.op == fca_pkg::U_FLAG_RD);
        flag_ra = r_quo[IDX_W-1:0];
        case (ctrl.op)
            fca_pkg::U_CLR_MEM: begin
                stk_we  = 1'b1;
                stk_wa  = r_cnt[IDX_W-1:0];
                stk_wd  = IDX_W'(r_num - 1'b1 - NUM_W'(r_cnt[IDX_W-1:0]));
                flag_we = 1'b1;
                flag_wa = r_cnt[IDX_W-1:0];
            end
            fca_pkg::U_POP: begin
                flag_we = 1'b1;
                flag_wa = r_stk_q;
                flag_wd = 1'b1;
            end
            fca_pkg::U_PUSH: begin
                flag_we = 1'b1;
                stk_we  = push_ok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_q <= r_stack[stk_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            r_flags[flag_wa] <= flag_wd;
        end
        if (flag_re) begin
            r_flag_q <= r_flags[flag_ra];
        end
    end

    // ---------------- condition flags ----------------
    always_comb begin
        flags.no_accept = !i_valid;
        flags.is_ret    = r_action;
        flags.stk_empty = (r_fc == '0);
        flags.cs_zero   = (r_csize == '0);
        flags.div_more  = (r_cnt != SCNT_W'(fca_pkg::DIV_STEPS - 1));
        flags.rem_nz    = (r_rem != '0);
        flags.quo_big   = (r_quo >= ADDR_W'(r_num));
        flags.flag_clr  = !r_flag_q;
        flags.out_full  = out_full;
        flags.clr_more  = (r_cnt[IDX_W-1:0] != IDX_W'(fca_pkg::MAX_CHUNKS - 1));
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc        <= fca_pkg::NUM_MAX;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (restart) begin
                r_fc  <= num_wr;
                r_cnt <= '0;
            end else begin
                case (ctrl.op)
                    fca_pkg::U_CLR_MEM: begin
                        r_fc  <= r_num;
                        r_cnt <= (r_cnt[IDX_W-1:0] == IDX_W'(fca_pkg::MAX_CHUNKS - 1))
                                 ? '0 : r_cnt + 1'b1;
                    end
                    fca_pkg::U_POP:      r_fc  <= r_fc - 1'b1;
                    fca_pkg::U_PUSH:     r_fc  <= push_ok ? r_fc + 1'b1 : r_fc;
                    fca_pkg::U_DIV_INIT: r_cnt <= '0;
                    fca_pkg::U_DIV_STEP: r_cnt <= r_cnt + 1'b1;
                    default: ;
                endcase
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        case (ctrl.op)
            fca_pkg::U_LOAD: begin
                if (in_xfer) begin
                    r_action <= i_action;
                    r_quo    <= i_address - r_base;
                    r_status <= fca_pkg::ST_OK;
                    r_gaddr  <= '0;
                    r_idx    <= '0;
                end
            end
            fca_pkg::U_POP: begin
                r_idx  <= r_stk_q;
                r_prod <= fca_pkg::PROD_W'(r_stk_q) * fca_pkg::PROD_W'(r_csize);
            end
            fca_pkg::U_GRANT:     r_gaddr  <= r_base + ADDR_W'(r_prod);
            fca_pkg::U_DIV_INIT:  r_rem    <= '0;
            fca_pkg::U_DIV_STEP: begin
                r_rem <= rem2;
                r_quo <= q2;
            end
            fca_pkg::U_FLAG_RD:   r_idx    <= r_quo[IDX_W-1:0];
            fca_pkg::U_SET_FREE:  r_status <= fca_pkg::ST_FREE;
            fca_pkg::U_SET_RANGE: r_status <= fca_pkg::ST_RANGE;
            fca_pkg::U_SET_MIS:   r_status <= fca_pkg::ST_MISALIGN;
            fca_pkg::U_SET_NONE:  r_status <= fca_pkg::ST_NONE;
            default: ;
        endcase
        if (emit) begin
            r_o_status <= r_status;
            r_o_gaddr  <= r_gaddr;
            r_o_idx    <= r_idx;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_o_status;
    assign o_granted_address = r_o_gaddr;
    assign o_chunk_index     = r_o_idx;

`ifndef ASSERT_OFF
    // free count never runs past the managed chunk count
    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= r_num)
        else $error("free count above num_chunks");

    // a result appears only from the emit step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(ctrl.op == fca_pkg::U_EMIT))
        else $error("result without emit step");

    // an accepted request always takes the sequencer busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("sequencer stayed idle after a transfer");

    // only a successful allocate grants a nonzero address
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_granted_address != '0)) |-> (o_status == fca_pkg::ST_OK))
        else $error("granted address on a failed request");
`endif

endmodule

`default_nettype wire

FILE: bench/fca_tb_pkg.sv
`timescale 1ns / 100ps
// Request codes and the predicted-result record used across the allocator bench.
// Depends on fca_pkg for widths and status codes.

package fca_tb_pkg;

    typedef enum logic {
        ACT_ALLOC  = 1'b0,
        ACT_RETURN = 1'b1
    } t_action;

    typedef struct packed {
        fca_pkg::t_status                status;
        logic [fca_pkg::ADDR_W-1:0]      granted;
        logic [fca_pkg::IDX_W-1:0]       index;
    } t_outcome;

endpackage

FILE: bench/chunk_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the fixed chunk allocator: follows APB register writes, predicts the result
// of every request transfer from its own free stack and compares every result transfer.
// Depends on fca_pkg and fca_tb_pkg.

module chunk_scoreboard (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    input  wire logic                          i_req_stall,
    input  wire logic                          i_action,
    input  wire logic [fca_pkg::ADDR_W-1:0]    i_address,
    input  wire logic                          i_res_valid,
    input  wire logic                          i_res_stall,
    input  wire logic [fca_pkg::ST_W-1:0]      i_status,
    input  wire logic [fca_pkg::ADDR_W-1:0]    i_granted,
    input  wire logic [fca_pkg::IDX_W-1:0]     i_index,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic                          i_pready,
    input  wire logic [fca_pkg::PADDR_W-1:0]   i_paddr,
    input  wire logic [fca_pkg::PDATA_W-1:0]   i_pwdata,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    localparam int ADDR_W = fca_pkg::ADDR_W;
    localparam int CS_W   = fca_pkg::CS_W;
    localparam int NUM_W  = fca_pkg::NUM_W;
    localparam int IDX_W  = fca_pkg::IDX_W;

    logic [ADDR_W-1:0] region_base;
    logic [CS_W-1:0]   chunk_bytes;
    logic [NUM_W-1:0]  chunk_total;

    logic [IDX_W-1:0]  free_idx [fca_pkg::MAX_CHUNKS];
    logic [NUM_W-1:0]  free_top;
    logic              chunk_busy [fca_pkg::MAX_CHUNKS];

    fca_tb_pkg::t_outcome awaited [$];

    // index 0 ends up on top of the stack
    task automatic refill_free_stack();
        for (int i = 0; i < fca_pkg::MAX_CHUNKS; i++) begin
            chunk_busy[i] = 1'b0;
            if (i < chunk_total)
                free_idx[i] = IDX_W'(chunk_total - NUM_W'(1) - NUM_W'(i));
        end
        free_top = chunk_total;
    endtask

    task automatic write_register(input logic [fca_pkg::PADDR_W-1:0] addr,
                                  input logic [fca_pkg::PDATA_W-1:0] data);
        case (addr[fca_pkg::PADDR_W-1:2])
            fca_pkg::REG_BASE:   region_base = data;
            fca_pkg::REG_CSIZE:  chunk_bytes = data[CS_W-1:0];
            fca_pkg::REG_NCHUNK: begin
                chunk_total = (data[NUM_W-1:0] > fca_pkg::NUM_MAX) ? fca_pkg::NUM_MAX
                                                                   : data[NUM_W-1:0];
                refill_free_stack();
            end
            default: ;
        endcase
    endtask

    task automatic serve_request(input logic act, input logic [ADDR_W-1:0] addr,
                                 output fca_tb_pkg::t_outcome res);
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] quot;
        logic [IDX_W-1:0]  idx;
        res = '{status: fca_pkg::ST_OK, granted: '0, index: '0};
        if (act == fca_tb_pkg::ACT_ALLOC) begin
            if (free_top == '0) begin
                res.status = fca_pkg::ST_NONE;
            end else begin
                idx = free_idx[IDX_W'(free_top - NUM_W'(1))];
                free_top = free_top - NUM_W'(1);
                chunk_busy[idx] = 1'b1;
                res.granted = region_base + ADDR_W'(idx) * ADDR_W'(chunk_bytes);
                res.index = idx;
            end
        end else begin
            // address below base wraps around and is checked as that wrapped offset
            offset = addr - region_base;
            if (chunk_bytes == '0 || offset % ADDR_W'(chunk_bytes) != '0) begin
                res.status = fca_pkg::ST_MISALIGN;
            end else begin
                quot = offset / ADDR_W'(chunk_bytes);
                if (quot >= ADDR_W'(chunk_total)) begin
                    res.status = fca_pkg::ST_RANGE;
                end else begin
                    idx = quot[IDX_W-1:0];
                    res.index = idx;
                    if (!chunk_busy[idx]) begin
                        res.status = fca_pkg::ST_FREE;
                    end else begin
                        chunk_busy[idx] = 1'b0;
                        if (free_top < chunk_total) begin
                            free_idx[free_top[IDX_W-1:0]] = idx;
                            free_top = free_top + NUM_W'(1);
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        fca_tb_pkg::t_outcome want;
        if (!i_rst_n) begin
            region_base = '0;
            chunk_bytes = fca_pkg::CS_RESET;
            chunk_total = fca_pkg::NUM_MAX;
            refill_free_stack();
            awaited.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_register(i_paddr, i_pwdata);
            if (i_res_valid && !i_res_stall) begin
                if (awaited.size() == 0) begin
                    $error("result transfer with no request outstanding: status %0d", i_status);
                    o_fail_count++;
                end else begin
                    want = awaited.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_granted !== want.granted) begin
                        $error("granted_address: expected %h, got %h", want.granted, i_granted);
                        o_fail_count++;
                    end
                    if (i_index !== want.index) begin
                        $error("chunk_index: expected %0d, got %0d", want.index, i_index);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                serve_request(i_action, i_address, want);
                awaited.push_back(want);
            end
        end
        o_pending = awaited.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Bench top for the fixed chunk allocator: clock, reset, request and register stimulus,
// result-side stalls and the verdict. Depends on fca_pkg, fca_tb_pkg and chunk_scoreboard.

module tb_top;

    localparam int CYCLE_LIMIT     = 600_000;
    localparam int HOLD_CYCLES     = 200;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PHASES          = 8;

    localparam int ADDR_W  = fca_pkg::ADDR_W;
    localparam int CS_W    = fca_pkg::CS_W;
    localparam int PADDR_W = fca_pkg::PADDR_W;
    localparam int PDATA_W = fca_pkg::PDATA_W;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_action;
    logic [ADDR_W-1:0]             i_address;
    logic                          o_valid;
    logic                          i_stall;
    logic [fca_pkg::ST_W-1:0]      o_status;
    logic [ADDR_W-1:0]             o_granted_address;
    logic [fca_pkg::IDX_W-1:0]     o_chunk_index;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [PADDR_W-1:0]            paddr;
    logic [PDATA_W-1:0]            pwdata;
    logic [PDATA_W-1:0]            prdata;
    logic                          pready;

    int                   mismatches;
    int                   outstanding;

    int                   tx_idle_pct;
    int                   rx_stall_pct;
    int                   hold_reqs;

    // region as last written, used to aim return addresses
    logic [ADDR_W-1:0]    cur_base;
    logic [CS_W-1:0]      cur_csize;
    int                   cur_chunks;

    logic [ADDR_W-1:0]    held_addrs [$];
    logic [ADDR_W-1:0]    returned_addrs [$];
    fca_tb_pkg::t_action  sent_kinds [$];

    fixed_chunk_allocator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_action          (i_action),
        .i_address         (i_address),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_chunk_index     (o_chunk_index),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    chunk_scoreboard chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_status     (o_status),
        .i_granted    (o_granted_address),
        .i_index      (o_chunk_index),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (mismatches),
        .o_pending    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    // granted addresses feed well-formed returns
    always @(posedge i_clk) begin : track_grants
        fca_tb_pkg::t_action kind;
        if (i_rst_n && i_valid && !o_stall)
            sent_kinds.push_back(fca_tb_pkg::t_action'(i_action));
        if (i_rst_n && o_valid && !i_stall && sent_kinds.size() > 0) begin
            kind = sent_kinds.pop_front();
            if (kind == fca_tb_pkg::ACT_ALLOC && o_status == fca_pkg::ST_OK)
                held_addrs.push_back(o_granted_address);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic offer(input fca_tb_pkg::t_action act, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_address <= addr;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // a chunk count write also rebuilds the free stack, so it goes last
    task automatic set_region(input logic [ADDR_W-1:0] base, input logic [CS_W-1:0] csize,
                              input int chunks);
        wait_drained();
        apb_write(fca_pkg::REG_BASE, base);
        apb_write(fca_pkg::REG_CSIZE, PDATA_W'(csize));
        apb_write(fca_pkg::REG_NCHUNK, PDATA_W'(chunks));
        cur_base   = base;
        cur_csize  = csize;
        cur_chunks = (chunks > fca_pkg::MAX_CHUNKS) ? fca_pkg::MAX_CHUNKS : chunks;
        held_addrs.delete();
        returned_addrs.delete();
    endtask

    task automatic pick_request(output fca_tb_pkg::t_action act,
                                output logic [ADDR_W-1:0] addr);
        int                roll;
        int                j;
        logic [ADDR_W-1:0] k;
        roll = $urandom_range(0, 99);
        act  = fca_tb_pkg::ACT_RETURN;
        addr = $urandom;
        if (roll < 45 || (roll < 78 && held_addrs.size() == 0)) begin
            act = fca_tb_pkg::ACT_ALLOC;
        end else if (roll < 78) begin
            j = $urandom_range(0, held_addrs.size() - 1);
            addr = held_addrs[j];
            held_addrs.delete(j);
            returned_addrs.push_back(addr);
            if (returned_addrs.size() > 32)
                void'(returned_addrs.pop_front());
        end else if (roll < 84 && returned_addrs.size() > 0) begin
            // likely a double return
            addr = returned_addrs[$urandom_range(0, returned_addrs.size() - 1)];
        end else if (roll < 92) begin
            k = (roll < 89) ? $urandom_range(0, cur_chunks + 8) : $urandom_range(0, 4095);
            addr = cur_base + k * cur_csize;
        end else if (roll < 96) begin
            k = $urandom_range(0, cur_chunks);
            addr = cur_base + k * cur_csize
                 + $urandom_range(1, (cur_csize > 1) ? cur_csize - 1 : 1);
        end
    endtask

    task automatic run_phase(input int p);
        logic [ADDR_W-1:0]   b;
        fca_tb_pkg::t_action act;
        logic [ADDR_W-1:0]   addr;
        b = $urandom;
        case (p)
            0:       set_region(b, CS_W'($urandom_range(1, 128)), $urandom_range(1, 32));
            1:       set_region(b | 32'hFFFF_F000, 16'hFFFF, fca_pkg::MAX_CHUNKS);
            2:       set_region(b, CS_W'(1 << $urandom_range(0, 15)), $urandom_range(1, 16));
            3:       set_region(b, CS_W'($urandom), 2047);
            4:       set_region(b, 16'd1, 1);
            5:       set_region('0, CS_W'($urandom_range(1, 64)), $urandom_range(1, 64));
            6:       set_region(b, 16'd0, 8);
            default: set_region(32'hFFFF_FFFF, CS_W'($urandom_range(1, 300)),
                                $urandom_range(1, 40));
        endcase
        case (p % 4)
            0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin tx_idle_pct = 69; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 69; end
            default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
        endcase
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == 40 && (p == 0 || p == 4))
                hold_reqs <= hold_reqs + 1;
            if (i == 75)
                wait_drained();
            pick_request(act, addr);
            offer(act, addr);
        end
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_action  <= fca_tb_pkg::ACT_ALLOC;
        i_address <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        hold_reqs <= 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        cur_base   = '0;
        cur_csize  = fca_pkg::CS_RESET;
        cur_chunks = fca_pkg::MAX_CHUNKS;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset region: base 0, 64-byte chunks, full capacity
        offer(fca_tb_pkg::ACT_ALLOC, 32'hFFFF_FFFF);
        offer(fca_tb_pkg::ACT_ALLOC, 32'h0000_0000);
        offer(fca_tb_pkg::ACT_RETURN, 32'd64);
        offer(fca_tb_pkg::ACT_RETURN, 32'd64);
        offer(fca_tb_pkg::ACT_RETURN, 32'd65);
        offer(fca_tb_pkg::ACT_RETURN, 32'd65536);
        offer(fca_tb_pkg::ACT_RETURN, 32'hFFFF_FFC0);
        offer(fca_tb_pkg::ACT_RETURN, 32'hFFFF_FFFF);
        offer(fca_tb_pkg::ACT_RETURN, 32'd0);

        // grants wrap past the top of the address space; stack runs dry
        set_region(32'hFFFF_FF00, 16'hFFFF, 2);
        offer(fca_tb_pkg::ACT_ALLOC, 32'h0);
        offer(fca_tb_pkg::ACT_ALLOC, 32'h0);
        offer(fca_tb_pkg::ACT_ALLOC, 32'h0);
        offer(fca_tb_pkg::ACT_RETURN, 32'h0000_0000);
        offer(fca_tb_pkg::ACT_RETURN, 32'h0000_FEFF);
        offer(fca_tb_pkg::ACT_RETURN, 32'hFFFF_FF00);
        offer(fca_tb_pkg::ACT_RETURN, 32'h0001_FEFE);

        // no chunks and zero size
        set_region(32'h0000_1000, 16'd0, 0);
        offer(fca_tb_pkg::ACT_ALLOC, 32'h0);
        offer(fca_tb_pkg::ACT_RETURN, 32'h0000_1000);

        // count beyond capacity saturates
        set_region(32'h0, 16'd1, 2047);
        offer(fca_tb_pkg::ACT_RETURN, 32'd5);
        offer(fca_tb_pkg::ACT_ALLOC, 32'h0);
        offer(fca_tb_pkg::ACT_RETURN, 32'd1024);

        set_region(32'h20, 16'd1, 0);
        offer(fca_tb_pkg::ACT_RETURN, 32'h20);

        // zero size hands out the base for every chunk
        set_region(32'h8000_0000, 16'd0, 3);
        offer(fca_tb_pkg::ACT_ALLOC, 32'h0);
        offer(fca_tb_pkg::ACT_ALLOC, 32'h0);

        for (int p = 0; p < PHASES; p++)
            run_phase(p);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
